// ===== design/aoct_pkg.sv =====
// package: opcodes and status codes for the a-star node table
package aoct_pkg;
	typedef enum logic [2:0] {
		OP_OFFER = 3'd0,
		OP_POP   = 3'd1,
		OP_CLOSE = 3'd2,
		OP_GOAL  = 3'd3,
		OP_READ  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;
endpackage

// ===== design/astar_open_closed_table.sv =====
// top level: a-star open/closed node table with a sequential scan
// operations: offer, pop and add goal scan the used entries, one per cycle, and
//   then pass the decide, read, wait and output states; close and read in range
// fetch the entry instead; clear, misses and unused opcodes go to output
// throughput: one item at a time, busy is low again in the result strobe cycle
// reset: asynchronous, clears the used count, open count and best goal
module astar_open_closed_table #(
	parameter int NODE_SLOTS = 256,
	parameter int EDGE_BITS  = 16,
	parameter int COST_BITS  = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           opcode,
	input  logic [EDGE_BITS-1:0] edge_id,
	input  logic signed [8:0]    parent_index,
	input  logic [7:0]           node_index,
	input  logic [COST_BITS-1:0] path_cost,
	input  logic [COST_BITS-1:0] heuristic,
	output logic                 done,
	output logic [1:0]           status,
	output logic [7:0]           slot,
	output logic [EDGE_BITS-1:0] slot_edge,
	output logic signed [8:0]    slot_parent,
	output logic [COST_BITS-1:0] slot_cost,
	output logic signed [8:0]    best_goal,
	output logic                 open_empty
);
	import aoct_pkg::*;

	localparam int IW = $clog2(NODE_SLOTS);
	localparam int CW = IW + 1;
	localparam logic [COST_BITS-1:0] CMAX = {COST_BITS{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_FETCH, S_DECIDE, S_READ, S_WAIT, S_OUT
	} state_t;
	state_t state_q;

	logic [EDGE_BITS-1:0] mem_edge   [NODE_SLOTS];
	logic [8:0]           mem_par    [NODE_SLOTS];
	logic [COST_BITS-1:0] mem_cost   [NODE_SLOTS];
	logic [COST_BITS-1:0] mem_tot    [NODE_SLOTS];
	logic                 mem_open   [NODE_SLOTS];
	logic                 mem_closed [NODE_SLOTS];

	logic [CW-1:0] used_q;
	logic [CW-1:0] open_cnt_q;
	logic goal_none_q;
	logic [IW-1:0] goal_idx_q;
	logic [COST_BITS-1:0] goal_cost_q;

	logic [2:0] op_q;
	logic [EDGE_BITS-1:0] edge_q;
	logic [8:0] par_q;
	logic [COST_BITS-1:0] cost_q, tot_q;
	logic [CW-1:0] scan_q;   // address issued
	logic [CW-1:0] rd_idx_q; // address of data now in rd_*
	logic rd_v_q;
	logic [EDGE_BITS-1:0] rd_edge_q;
	logic [8:0] rd_par_q;
	logic [COST_BITS-1:0] rd_tot_q;
	logic rd_open_q, rd_closed_q;
	logic found_q;
	logic [IW-1:0] hit_q;
	logic [COST_BITS-1:0] hit_tot_q;
	logic [8:0] hit_par_q;
	logic hit_open_q, hit_closed_q;

	logic [COST_BITS:0] sum;
	logic [IW-1:0] raddr;
	logic rd_en;
	logic we;
	logic wf;
	logic [IW-1:0] waddr;
	logic [EDGE_BITS-1:0] w_edge;
	logic [8:0] w_par;
	logic [COST_BITS-1:0] w_cost, w_tot;
	logic w_open, w_closed;

	assign sum = {1'b0, path_cost} + {1'b0, heuristic};
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_edge[waddr] <= w_edge;
			mem_par[waddr]  <= w_par;
			mem_cost[waddr] <= w_cost;
			mem_tot[waddr]  <= w_tot;
		end
		if (wf) begin
			mem_open[waddr]   <= w_open;
			mem_closed[waddr] <= w_closed;
		end
		if (rd_en) begin
			rd_edge_q   <= mem_edge[raddr];
			rd_par_q    <= mem_par[raddr];
			rd_tot_q    <= mem_tot[raddr];
			rd_open_q   <= mem_open[raddr];
			rd_closed_q <= mem_closed[raddr];
		end
	end

	logic scan_more;
	assign scan_more = (scan_q < used_q);
	always_comb begin
		rd_en = 1'b0;
		raddr = scan_q[IW-1:0];
		if (state_q == S_SCAN && scan_more) rd_en = 1'b1;
		if (state_q == S_FETCH) begin
			rd_en = 1'b1;
			raddr = hit_q;
		end
	end

	// one compare unit per scan step
	logic match;
	always_comb begin
		match = 1'b0;
		if (op_q == OP_POP)
			match = rd_open_q && (!found_q || rd_tot_q < hit_tot_q);
		else
			match = !found_q && rd_edge_q == edge_q;
	end

	logic [IW-1:0] used_i;
	assign used_i = used_q[IW-1:0];

	// decide step
	logic full;
	logic offer_ignore;
	assign full = (used_q == CW'(NODE_SLOTS));
	assign offer_ignore = (hit_open_q || hit_closed_q) && hit_tot_q < tot_q;
	always_comb begin
		we = 1'b0;
		wf = 1'b0;
		waddr = hit_q;
		w_edge = edge_q;
		w_par = par_q;
		w_cost = cost_q;
		w_tot = tot_q;
		w_open = 1'b0;
		w_closed = hit_closed_q;
		if (state_q == S_DECIDE) begin
			case (op_q)
				OP_OFFER: begin
					if (!found_q) begin
						we = !full;
						wf = !full;
						waddr = used_i;
						w_open = 1'b1;
						w_closed = 1'b0;
					end else if (!offer_ignore) begin
						we = 1'b1;
						if (hit_closed_q) begin
							wf = 1'b1;
							w_open = 1'b1;
							w_closed = 1'b0;
						end
					end
				end
				OP_POP: begin
					if (found_q) wf = 1'b1;
				end
				OP_CLOSE: begin
					wf = 1'b1;
					w_closed = 1'b1;
				end
				OP_GOAL: begin
					if (found_q) begin
						we = 1'b1;
						w_par = hit_par_q;
						w_tot = cost_q;
					end
				end
				default: ;
			endcase
		end
	end

	logic [1:0] st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			open_cnt_q <= '0;
			goal_none_q <= 1'b1;
			goal_idx_q <= '0;
			goal_cost_q <= '0;
			done <= 1'b0;
			found_q <= 1'b0;
			rd_v_q <= 1'b0;
			st_q <= ST_DONE;
		end else begin
			done <= 1'b0;
			rd_v_q <= rd_en && state_q == S_SCAN;
			rd_idx_q <= scan_q;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= opcode;
						edge_q <= edge_id;
						par_q <= parent_index;
						cost_q <= path_cost;
						tot_q <= sum[COST_BITS] ? CMAX : sum[COST_BITS-1:0];
						scan_q <= '0;
						found_q <= 1'b0;
						hit_q <= '0;
						st_q <= ST_DONE;
						case (opcode)
							OP_OFFER, OP_POP, OP_GOAL: state_q <= S_SCAN;
							OP_CLOSE, OP_READ: begin
								if ({24'd0, node_index} >= 32'(used_q) ||
								    {24'd0, node_index} >= 32'(NODE_SLOTS)) begin
									st_q <= ST_EMPTY;
									state_q <= S_OUT;
								end else begin
									found_q <= 1'b1;
									hit_q <= IW'(node_index);
									state_q <= S_FETCH;
								end
							end
							OP_CLEAR: begin
								used_q <= '0;
								open_cnt_q <= '0;
								goal_none_q <= 1'b1;
								goal_idx_q <= '0;
								goal_cost_q <= '0;
								state_q <= S_OUT;
							end
							default: begin
								st_q <= ST_EMPTY;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_more) scan_q <= scan_q + 1'b1;
					if (rd_v_q && match) begin
						found_q <= 1'b1;
						hit_q <= rd_idx_q[IW-1:0];
						hit_tot_q <= rd_tot_q;
						hit_par_q <= rd_par_q;
						hit_open_q <= rd_open_q;
						hit_closed_q <= rd_closed_q;
					end
					if (!scan_more && !rd_v_q) state_q <= S_DECIDE;
				end
				S_FETCH: state_q <= S_DECIDE;
				S_DECIDE: begin
					state_q <= S_READ;
					case (op_q)
						OP_OFFER: begin
							if (!found_q) begin
								if (full) st_q <= ST_FULL;
								else begin
									hit_q <= used_i;
									used_q <= used_q + 1'b1;
									open_cnt_q <= open_cnt_q + 1'b1;
								end
							end else if (offer_ignore) begin
								st_q <= ST_IGNORED;
							end else if (hit_closed_q) begin
								open_cnt_q <= open_cnt_q + 1'b1;
							end
						end
						OP_POP: begin
							if (!found_q) st_q <= ST_EMPTY;
							else open_cnt_q <= open_cnt_q - 1'b1;
						end
						OP_CLOSE: begin
							if (rd_open_q) open_cnt_q <= open_cnt_q - 1'b1;
						end
						OP_GOAL: begin
							if (!found_q) st_q <= ST_EMPTY;
							else if (goal_none_q || cost_q < goal_cost_q) begin
								goal_none_q <= 1'b0;
								goal_idx_q <= hit_q;
								goal_cost_q <= cost_q;
							end
						end
						default: ;
					endcase
				end
				S_READ: begin
					// write then reread so the output sees updated entry
					state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_OUT;
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output read after the write has landed
	logic [EDGE_BITS-1:0] o_edge_q;
	logic [8:0] o_par_q;
	logic [COST_BITS-1:0] o_cost_q;
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			o_edge_q <= mem_edge[hit_q];
			o_par_q  <= mem_par[hit_q];
			o_cost_q <= mem_cost[hit_q];
		end
	end

	logic show;
	assign show = done && (st_q == ST_DONE || st_q == ST_IGNORED) && op_q != OP_CLEAR;
	assign status = st_q;
	assign slot = show ? 8'(hit_q) : '0;
	assign slot_edge = show ? o_edge_q : '0;
	assign slot_parent = show ? o_par_q : '0;
	assign slot_cost = show ? o_cost_q : '0;
	assign best_goal = goal_none_q ? 9'h1ff : 9'(goal_idx_q);
	assign open_empty = (open_cnt_q == '0);
endmodule

// ===== design/aoct_checker.sv =====
// checker: port-level properties of the a-star node table
module aoct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] slot
);
	import aoct_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during result");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result repeated");
	a_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY || status == ST_FULL) |-> slot == 8'd0)
		else $error("slot on failure");
endmodule

bind astar_open_closed_table aoct_checker u_aoct_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .status(status), .slot(slot)
);
